// ===== rtl/bdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int MODE_W  = 3;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_DUMP       = 3'd4
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

endpackage : bdq_pkg
`default_nettype wire

// ===== rtl/bdq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_in_if / bdq_out_if
// Valid/ready channels for requests into and results out of the deque.
// ----------------------------------------------------------------------------
interface bdq_in_if;
  logic                       valid;
  logic                       ready;
  logic [bdq_pkg::MODE_W-1:0] mode;
  bdq_pkg::word_t             value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface : bdq_in_if

interface bdq_out_if;
  logic                       valid;
  logic                       ready;
  logic [bdq_pkg::STAT_W-1:0] status;
  bdq_pkg::word_t             data;
  logic                       backward;
  logic [bdq_pkg::OCC_W-1:0]  occupancy;
  logic                       last;

  modport source (output valid, output status, output data, output backward,
                  output occupancy, output last, input ready);
  modport sink   (input valid, input status, input data, input backward,
                  input occupancy, input last, output ready);
endinterface : bdq_out_if
`default_nettype wire

// ===== rtl/bdq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ram
// Element store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire bdq_pkg::word_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output bdq_pkg::word_t      rdata_r
);
  import bdq_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule : bdq_ram
`default_nettype wire

// ===== rtl/bdq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Ring pointers, request decode, dump sequencer and the result register.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
  parameter int CAPACITY = 16,
  parameter int PW       = 4,
  parameter int CW       = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  bdq_in_if.sink             in_ch,
  bdq_out_if.source          out_ch,
  output logic               ram_we,
  output logic [PW-1:0]      ram_waddr,
  output bdq_pkg::word_t     ram_wdata,
  output logic [PW-1:0]      ram_raddr,
  input  wire bdq_pkg::word_t ram_rdata
);
  import bdq_pkg::*;

  localparam logic [PW:0]   CAP_P = (PW+1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [PW-1:0] TOP_P = PW'(CAPACITY - 1);

  // Ring position that lies off places past base, wrapping at CAPACITY.
  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                             input logic [PW-1:0] off);
    logic [PW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_P) begin
      sum = sum - CAP_P;
    end
    return sum[PW-1:0];
  endfunction

  state_t          state_r, state_nxt;
  logic [PW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   off_r, off_nxt;
  logic            back_r, back_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  word_t           data_r, data_nxt;
  logic            backward_r, backward_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic            last_r, last_nxt;

  logic            out_free;
  logic            in_acc;
  logic [PW-1:0]   front_dec;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign front_dec = (front_r == '0) ? TOP_P : front_r - PW'(1);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.data      = data_r;
  assign out_ch.backward  = backward_r;
  assign out_ch.occupancy = occ_r;
  assign out_ch.last      = last_r;

  // The read address follows the next dump offset, so the registered read
  // data always belongs to the offset held in off_r.
  assign ram_raddr = ring_add(front_r, off_nxt);

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    off_nxt       = off_r;
    back_nxt      = back_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    data_nxt      = data_r;
    backward_nxt  = backward_r;
    occ_nxt       = occ_r;
    last_nxt      = last_r;
    ram_we        = 1'b0;
    ram_waddr     = front_dec;
    ram_wdata     = in_ch.value;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          status_nxt   = STAT_OK;
          data_nxt     = '0;
          backward_nxt = 1'b0;
          last_nxt     = 1'b1;
          case (in_ch.mode)
            MODE_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (count_r == CAP_C) begin
                status_nxt = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            MODE_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (count_r == CAP_C) begin
                status_nxt = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(front_r, count_r[PW-1:0]);
                count_nxt = count_r + CW'(1);
              end
            end
            MODE_POP_FRONT: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                front_nxt = ring_add(front_r, PW'(1));
                count_nxt = count_r - CW'(1);
              end
            end
            MODE_POP_BACK: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            MODE_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = STAT_EMPTY;
              end else begin
                state_nxt = ST_DUMP;
                off_nxt   = '0;
                back_nxt  = 1'b0;
              end
            end
            default: begin
              // Unused codes are taken and produce no result.
            end
          endcase
          occ_nxt = OCC_W'(count_nxt);
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          data_nxt      = ram_rdata;
          backward_nxt  = back_r;
          occ_nxt       = OCC_W'(count_r);
          last_nxt      = back_r && (off_r == '0);
          if (!back_r) begin
            if ((CW'(off_r) + CW'(1)) == count_r) begin
              back_nxt = 1'b1;
            end else begin
              off_nxt = off_r + PW'(1);
            end
          end else if (off_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            off_nxt = off_r - PW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    back_r     <= back_nxt;
    status_r   <= status_nxt;
    data_r     <= data_nxt;
    backward_r <= backward_nxt;
    occ_r      <= occ_nxt;
    last_r     <= last_nxt;
  end

endmodule : bdq_ctrl
`default_nettype wire

// ===== rtl/bounded_deque.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed 32-bit words held in a ring buffer.
//
// Requests arrive on in_ch (mode, value) and results leave on out_ch
// (status, data, backward, occupancy, last); both use valid/ready and a
// transfer happens when both are high. Push and pop requests give one
// result, registered in the cycle after the transfer, and a new request
// can follow in the next cycle: one request per cycle while out_ch keeps up.
// A dump of n elements gives 2*n results, front to back and then back to
// front, the first from the registered read data once in the dump state,
// then one per cycle while out_ch keeps up; it walks the element memory
// through its single read port and holds in_ch.ready low until its final
// result is loaded. Unused mode codes are taken and give no result.
// The result sits in an output register; when out_ch stalls, in_ch.ready
// drops only until that register can be reloaded.
// Reset empties the deque (front pointer and count cleared); the element
// memory needs no clearing pass because only written entries are read.
// ----------------------------------------------------------------------------
module bounded_deque #(
  parameter int CAPACITY = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bdq_in_if.sink      in_ch,
  bdq_out_if.source   out_ch
);
  import bdq_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  word_t         ram_wdata;
  logic [PW-1:0] ram_raddr;
  word_t         ram_rdata;

  bdq_ctrl #(
    .CAPACITY (CAPACITY),
    .PW       (PW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bdq_ram #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

endmodule : bounded_deque
`default_nettype wire

// ===== tb/bounded_deque_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_tb
// Self-checking bench for the bounded double-ended queue. A shadow deque
// predicts every result but those of typed directed rows, given by hand.
// A short table of directed requests comes first, then random fill,
// drain, mixed and dump sequences. Both channels idle at random, and the
// result side is held off once so the input stalls; pushes then fill it up.
// ----------------------------------------------------------------------------
module bounded_deque_tb;
  import bdq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int IDLE_PCT     = 6;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 215;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIRECTED   = 21;

  // Mode codes outside the enum; the block takes them and stays silent.
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t ALL_ONES = -32'sd1;

  typedef struct {
    status_t          status;
    word_t            data;
    logic             backward;
    logic [OCC_W-1:0] occ;
    logic             last;
  } result_t;

  typedef result_t result_q_t [$];

  typedef struct {
    logic [MODE_W-1:0] mode;
    word_t             value;
    bit                typed;
    status_t           status;
    logic [OCC_W-1:0]  occ;
  } stim_row_t;

  // Rows marked typed carry their result by hand; the rest use the shadow deque.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{MODE_POP_FRONT,  32'sd0,          1'b1, STAT_EMPTY, 5'd0},
    '{MODE_POP_BACK,   ALL_ONES,        1'b1, STAT_EMPTY, 5'd0},
    '{MODE_DUMP,       32'sd0,          1'b1, STAT_EMPTY, 5'd0},
    '{MODE_UNUSED_LO,  32'sh5555_5555,  1'b0, STAT_OK,    5'd0},
    '{MODE_UNUSED_HI,  ALL_ONES,        1'b0, STAT_OK,    5'd0},
    '{MODE_PUSH_BACK,  WORD_MAX,        1'b1, STAT_OK,    5'd1},
    '{MODE_POP_BACK,   32'sd0,          1'b1, STAT_OK,    5'd0},
    '{MODE_PUSH_FRONT, WORD_MIN,        1'b1, STAT_OK,    5'd1},
    '{MODE_POP_FRONT,  32'sd0,          1'b1, STAT_OK,    5'd0},
    '{MODE_PUSH_BACK,  WORD_MIN,        1'b1, STAT_OK,    5'd1},
    '{MODE_DUMP,       32'sd0,          1'b0, STAT_OK,    5'd0},
    '{MODE_PUSH_FRONT, WORD_MAX,        1'b0, STAT_OK,    5'd0},
    '{MODE_PUSH_BACK,  ALL_ONES,        1'b0, STAT_OK,    5'd0},
    '{MODE_PUSH_FRONT, 32'shA5A5_5A5A,  1'b0, STAT_OK,    5'd0},
    '{MODE_DUMP,       32'sd0,          1'b0, STAT_OK,    5'd0},
    '{MODE_POP_BACK,   32'sd0,          1'b0, STAT_OK,    5'd0},
    '{MODE_POP_FRONT,  32'sd0,          1'b0, STAT_OK,    5'd0},
    '{MODE_DUMP,       32'sd0,          1'b0, STAT_OK,    5'd0},
    '{MODE_POP_FRONT,  32'sd0,          1'b0, STAT_OK,    5'd0},
    '{MODE_POP_BACK,   32'sd0,          1'b0, STAT_OK,    5'd0},
    '{MODE_POP_FRONT,  32'sd0,          1'b1, STAT_EMPTY, 5'd0}
  };

  logic clk;
  logic rst_n;

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  bit mismatch_seen = 1'b0;
  int useful_sent;

  // Shadow copy of the deque.
  word_t              shadow_mem [DEPTH];
  logic [PTR_W-1:0]   shadow_head = '0;
  logic [OCC_W-1:0]   shadow_fill = '0;

  result_q_t due_results;

  bdq_in_if  req_if ();
  bdq_out_if res_if ();

  bounded_deque #(.CAPACITY(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic result_q_t apply_deque_op(input logic [MODE_W-1:0] mode,
                                               input word_t value);
    result_q_t res;
    logic [PTR_W-1:0] slot;
    res = {};
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (shadow_fill == DEPTH) begin
          res.push_back('{STAT_FULL, '0, 1'b0, shadow_fill, 1'b1});
        end else begin
          if (mode == MODE_PUSH_FRONT) begin
            shadow_head = PTR_W'((shadow_head + DEPTH - 1) % DEPTH);
            shadow_mem[shadow_head] = value;
          end else begin
            slot = PTR_W'((shadow_head + shadow_fill) % DEPTH);
            shadow_mem[slot] = value;
          end
          shadow_fill++;
          res.push_back('{STAT_OK, '0, 1'b0, shadow_fill, 1'b1});
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (shadow_fill == 0) begin
          res.push_back('{STAT_EMPTY, '0, 1'b0, shadow_fill, 1'b1});
        end else begin
          if (mode == MODE_POP_FRONT) shadow_head = PTR_W'((shadow_head + 1) % DEPTH);
          shadow_fill--;
          res.push_back('{STAT_OK, '0, 1'b0, shadow_fill, 1'b1});
        end
      end
      MODE_DUMP: begin
        if (shadow_fill == 0) begin
          res.push_back('{STAT_EMPTY, '0, 1'b0, shadow_fill, 1'b1});
        end else begin
          for (int i = 0; i < shadow_fill; i++) begin
            slot = PTR_W'((shadow_head + i) % DEPTH);
            res.push_back('{STAT_OK, shadow_mem[slot], 1'b0, shadow_fill, 1'b0});
          end
          for (int i = shadow_fill - 1; i >= 0; i--) begin
            slot = PTR_W'((shadow_head + i) % DEPTH);
            res.push_back('{STAT_OK, shadow_mem[slot], 1'b1, shadow_fill, i == 0});
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return ALL_ONES;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Offers one request and books its results once the transfer happens.
  task automatic send_req(input logic [MODE_W-1:0] mode, input word_t value,
                          input bit typed = 1'b0, input status_t status = STAT_OK,
                          input logic [OCC_W-1:0] occ = '0);
    result_q_t fresh;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= mode;
    req_if.value <= value;
    do @(posedge clk); while (!req_if.ready);
    fresh = apply_deque_op(mode, value);
    if (typed) fresh = '{'{status, '0, 1'b0, occ, 1'b1}};
    foreach (fresh[i]) due_results.push_back(fresh[i]);
    if (mode <= MODE_DUMP) useful_sent++;
  endtask

  function automatic logic [MODE_W-1:0] rand_push();
    return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
  endfunction

  function automatic logic [MODE_W-1:0] rand_pop();
    return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
  endfunction

  initial begin : stimulus
    int n;
    req_if.valid <= 1'b0;
    req_if.mode  <= MODE_PUSH_FRONT;
    req_if.value <= '0;
    rst_n        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_req(directed_rows[i].mode, directed_rows[i].value, directed_rows[i].typed,
               directed_rows[i].status, directed_rows[i].occ);
    end

    // Hold the result side off while requests keep coming; the deque fills,
    // runs into full errors and the input stalls behind the output register.
    hold_req <= 1'b1;
    repeat (DEPTH + 4) send_req(rand_push(), rand_word());
    send_req(MODE_DUMP, '0);

    useful_sent = 0;
    while (useful_sent < RANDOM_ITEMS) begin
      steady <= (useful_sent >= 110 && useful_sent < 170);
      case ($urandom_range(0, 9))
        0: begin
          while (shadow_fill < DEPTH) send_req(rand_push(), rand_word());
          send_req(rand_push(), rand_word());
          if ($urandom_range(0, 1)) send_req(MODE_DUMP, '0);
        end
        1: begin
          while (shadow_fill > 0) send_req(rand_pop(), rand_word());
          send_req($urandom_range(0, 1) ? rand_pop() : MODE_DUMP, rand_word());
        end
        2, 3: begin
          n = $urandom_range(1, 6);
          repeat (n) send_req(rand_push(), rand_word());
        end
        4, 5: begin
          n = $urandom_range(1, 6);
          repeat (n) send_req(rand_pop(), rand_word());
        end
        6, 7: begin
          repeat (8) begin
            send_req(MODE_W'($urandom_range(MODE_PUSH_FRONT, MODE_DUMP)), rand_word());
          end
        end
        8: send_req(MODE_DUMP, rand_word());
        default: begin
          repeat (3) begin
            send_req(MODE_W'($urandom_range(0, MODE_UNUSED_HI)), word_t'($urandom));
          end
        end
      endcase
    end
    req_if.valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!mismatch_seen) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_pacing
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string label, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result transfer with none expected, got status %0d data %0d",
                 $time, res_if.status, res_if.data);
        mismatch_seen = 1'b1;
      end else begin
        want = due_results.pop_front();
        check_field("status",    64'(want.status),   64'(res_if.status));
        check_field("data",      64'(want.data),     64'(res_if.data));
        check_field("backward",  64'(want.backward), 64'(res_if.backward));
        check_field("occupancy", 64'(want.occ),      64'(res_if.occupancy));
        check_field("last",      64'(want.last),     64'(res_if.last));
      end
    end
  end

endmodule : bounded_deque_tb

// ===== filelist.f =====
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque.sv
tb/bounded_deque_tb.sv
